FILE: rtl/depth_pixel_backprojection_macros.svh
// Assertion macros used by the depth backprojection checker.
`ifndef DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH

// Checked only while the block is out of reset.
`define DPB_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset cycles included.
`define DPB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/dpb_pkg.sv
// Shared constants, register map and types of the depth backprojection block.
package dpb_pkg;

  // Default for the largest image dimension, as a power of two.
  localparam int MAX_DIM_BITS_DEF = 12;

  // Field widths.
  localparam int DEPTH_W    = 16;
  localparam int COORD_W    = 24;
  localparam int POS_OUT_W  = 12;
  localparam int SIZE_W     = 13;
  localparam int STEP_W     = 5;
  localparam int PHASE_W    = 4;
  localparam int CXY_W      = 16;
  localparam int INV_W      = 24;
  localparam int FRAC_BITS  = 28;
  localparam int STEP_MAX   = 16;

  // Stream and configuration port widths.
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Saturation limits of the lateral coordinates, as magnitudes.
  localparam int COORD_POS_MAX = 8388607;
  localparam int COORD_NEG_MAG = 8388608;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PIX_STEP     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DEPTH    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PRINCIPAL_X  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PRINCIPAL_Y  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd7;

  // Register reset values.
  localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [STEP_W-1:0]  RST_PIX_STEP     = 5'd2;
  localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH    = 16'd4000;
  localparam logic [CXY_W-1:0]   RST_PRINCIPAL_X  = 16'd5120;
  localparam logic [CXY_W-1:0]   RST_PRINCIPAL_Y  = 16'd3840;
  localparam logic [INV_W-1:0]   RST_INV_FOCAL_X  = 24'd27962;
  localparam logic [INV_W-1:0]   RST_INV_FOCAL_Y  = 24'd27962;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [SIZE_W-1:0]  image_width;
    logic [SIZE_W-1:0]  image_height;
    logic [STEP_W-1:0]  pix_step;
    logic [DEPTH_W-1:0] max_depth_mm;
    logic [CXY_W-1:0]   principal_x;
    logic [CXY_W-1:0]   principal_y;
    logic [INV_W-1:0]   inv_focal_x;
    logic [INV_W-1:0]   inv_focal_y;
  } cfg_t;

endpackage

FILE: rtl/dpb_cfg.sv
// Configuration register file with an APB-style access port.
module dpb_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [dpb_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready,
  output dpb_pkg::cfg_t                     cfg
);

  dpb_pkg::cfg_t                   cfg_r, cfg_nxt;
  logic [dpb_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                            wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[dpb_pkg::CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        dpb_pkg::REG_IMAGE_WIDTH:  cfg_nxt.image_width  = dpb_pkg::SIZE_W'(cfg_pwdata);
        dpb_pkg::REG_IMAGE_HEIGHT: cfg_nxt.image_height = dpb_pkg::SIZE_W'(cfg_pwdata);
        dpb_pkg::REG_PIX_STEP:     cfg_nxt.pix_step     = dpb_pkg::STEP_W'(cfg_pwdata);
        dpb_pkg::REG_MAX_DEPTH:    cfg_nxt.max_depth_mm = dpb_pkg::DEPTH_W'(cfg_pwdata);
        dpb_pkg::REG_PRINCIPAL_X:  cfg_nxt.principal_x  = dpb_pkg::CXY_W'(cfg_pwdata);
        dpb_pkg::REG_PRINCIPAL_Y:  cfg_nxt.principal_y  = dpb_pkg::CXY_W'(cfg_pwdata);
        dpb_pkg::REG_INV_FOCAL_X:  cfg_nxt.inv_focal_x  = dpb_pkg::INV_W'(cfg_pwdata);
        dpb_pkg::REG_INV_FOCAL_Y:  cfg_nxt.inv_focal_y  = dpb_pkg::INV_W'(cfg_pwdata);
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register read mux.
  always_comb begin
    case (reg_idx)
      dpb_pkg::REG_IMAGE_WIDTH:  cfg_prdata = dpb_pkg::CFG_DATA_W'(cfg_r.image_width);
      dpb_pkg::REG_IMAGE_HEIGHT: cfg_prdata = dpb_pkg::CFG_DATA_W'(cfg_r.image_height);
      dpb_pkg::REG_PIX_STEP:     cfg_prdata = dpb_pkg::CFG_DATA_W'(cfg_r.pix_step);
      dpb_pkg::REG_MAX_DEPTH:    cfg_prdata = dpb_pkg::CFG_DATA_W'(cfg_r.max_depth_mm);
      dpb_pkg::REG_PRINCIPAL_X:  cfg_prdata = dpb_pkg::CFG_DATA_W'(cfg_r.principal_x);
      dpb_pkg::REG_PRINCIPAL_Y:  cfg_prdata = dpb_pkg::CFG_DATA_W'(cfg_r.principal_y);
      dpb_pkg::REG_INV_FOCAL_X:  cfg_prdata = dpb_pkg::CFG_DATA_W'(cfg_r.inv_focal_x);
      dpb_pkg::REG_INV_FOCAL_Y:  cfg_prdata = dpb_pkg::CFG_DATA_W'(cfg_r.inv_focal_y);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= dpb_pkg::RST_IMAGE_WIDTH;
      cfg_r.image_height <= dpb_pkg::RST_IMAGE_HEIGHT;
      cfg_r.pix_step     <= dpb_pkg::RST_PIX_STEP;
      cfg_r.max_depth_mm <= dpb_pkg::RST_MAX_DEPTH;
      cfg_r.principal_x  <= dpb_pkg::RST_PRINCIPAL_X;
      cfg_r.principal_y  <= dpb_pkg::RST_PRINCIPAL_Y;
      cfg_r.inv_focal_x  <= dpb_pkg::RST_INV_FOCAL_X;
      cfg_r.inv_focal_y  <= dpb_pkg::RST_INV_FOCAL_Y;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/dpb_front.sv
// Front end: accepts depth items, tracks pixel position and selects kept pixels.
module dpb_front #(
  parameter int MAX_DIM_BITS = dpb_pkg::MAX_DIM_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dpb_pkg::cfg_t                         cfg,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [dpb_pkg::IN_DATA_W-1:0]         in_tdata,
  input  logic [dpb_pkg::IN_USER_W-1:0]         in_tuser,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [dpb_pkg::DEPTH_W+2*MAX_DIM_BITS-1:0] q_data
);

  // Width that holds both the size registers and the size limit.
  localparam int CW = (MAX_DIM_BITS + 1 > dpb_pkg::SIZE_W) ? MAX_DIM_BITS + 1
                                                           : dpb_pkg::SIZE_W;
  localparam logic [CW-1:0] DIM_LIM = CW'(1) << MAX_DIM_BITS;

  logic [MAX_DIM_BITS-1:0]       col_r, col_nxt, row_r, row_nxt;
  logic [dpb_pkg::PHASE_W-1:0]   cph_r, cph_nxt, rph_r, rph_nxt;
  logic [MAX_DIM_BITS-1:0]       u, v;
  logic [dpb_pkg::PHASE_W-1:0]   cph, rph;
  logic [CW-1:0]                 w_ext, h_ext, w_eff, h_eff, u_inc, v_inc;
  logic [dpb_pkg::STEP_W-1:0]    step_eff, cph_inc, rph_inc;
  logic [dpb_pkg::DEPTH_W-1:0]   z;
  logic                          start, accept, keep;

  assign z         = in_tdata[dpb_pkg::DEPTH_W-1:0];
  assign start     = in_tuser[0];
  assign in_tready = !q_full;
  assign accept    = in_tvalid & in_tready;

  // Clamp frame size and step to their legal ranges.
  always_comb begin
    w_ext = CW'(cfg.image_width);
    h_ext = CW'(cfg.image_height);
    if (w_ext == '0)          w_eff = CW'(1);
    else if (w_ext > DIM_LIM) w_eff = DIM_LIM;
    else                      w_eff = w_ext;
    if (h_ext == '0)          h_eff = CW'(1);
    else if (h_ext > DIM_LIM) h_eff = DIM_LIM;
    else                      h_eff = h_ext;
    if (cfg.pix_step == '0)
      step_eff = dpb_pkg::STEP_W'(1);
    else if (cfg.pix_step > dpb_pkg::STEP_W'(dpb_pkg::STEP_MAX))
      step_eff = dpb_pkg::STEP_W'(dpb_pkg::STEP_MAX);
    else
      step_eff = cfg.pix_step;
  end

  // Position of this item; a frame start forces the origin.
  assign u   = start ? '0 : col_r;
  assign v   = start ? '0 : row_r;
  assign cph = start ? '0 : cph_r;
  assign rph = start ? '0 : rph_r;

  assign keep   = (cph == '0) && (rph == '0) && (z <= cfg.max_depth_mm);
  assign q_push = accept & keep;
  assign q_data = {v, u, z};

  // Advance column, row and the two phases.
  always_comb begin
    u_inc   = CW'(u) + CW'(1);
    v_inc   = CW'(v) + CW'(1);
    cph_inc = dpb_pkg::STEP_W'(cph) + dpb_pkg::STEP_W'(1);
    rph_inc = dpb_pkg::STEP_W'(rph) + dpb_pkg::STEP_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    cph_nxt = cph_r;
    rph_nxt = rph_r;
    if (accept) begin
      if (u_inc >= w_eff) begin
        col_nxt = '0;
        cph_nxt = '0;
        if (v_inc >= h_eff) begin
          row_nxt = '0;
          rph_nxt = '0;
        end else begin
          row_nxt = v_inc[MAX_DIM_BITS-1:0];
          rph_nxt = (rph_inc >= step_eff) ? '0 : rph_inc[dpb_pkg::PHASE_W-1:0];
          col_nxt = '0;
        end
      end else begin
        col_nxt = u_inc[MAX_DIM_BITS-1:0];
        cph_nxt = (cph_inc >= step_eff) ? '0 : cph_inc[dpb_pkg::PHASE_W-1:0];
        row_nxt = v;
        rph_nxt = rph;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      cph_r <= '0;
      rph_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cph_r <= cph_nxt;
      rph_r <= rph_nxt;
    end
  end

endmodule

FILE: rtl/dpb_queue.sv
// Short first-in first-out queue of kept pixels between front and back.
module dpb_queue #(
  parameter int W = dpb_pkg::DEPTH_W + 2 * dpb_pkg::MAX_DIM_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0]                ent_r [dpb_pkg::QUEUE_DEPTH];
  logic [dpb_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [dpb_pkg::QPTR_W:0]    count_r, count_nxt;
  logic                        do_push, do_pop;

  assign full      = (count_r == (dpb_pkg::QPTR_W+1)'(dpb_pkg::QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push & !full;
  assign do_pop    = pop & !empty;
  assign head_data = ent_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/dpb_back.sv
// Back end: projects kept pixels to points in a stalling four-stage pipeline.
module dpb_back #(
  parameter int MAX_DIM_BITS = dpb_pkg::MAX_DIM_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  dpb_pkg::cfg_t                              cfg,
  input  logic                                       q_empty,
  input  logic [dpb_pkg::DEPTH_W+2*MAX_DIM_BITS-1:0] q_data,
  output logic                                       q_pop,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output logic [dpb_pkg::OUT_DATA_W-1:0]             out_tdata
);

  // Offset magnitude width, first and second product widths, rounded width.
  localparam int MW  = (MAX_DIM_BITS + 4 > dpb_pkg::CXY_W) ? MAX_DIM_BITS + 4
                                                            : dpb_pkg::CXY_W;
  localparam int DW  = MW + 1;
  localparam int P1W = MW + dpb_pkg::DEPTH_W;
  localparam int P2W = P1W + dpb_pkg::INV_W;
  localparam int RW  = P2W + 1 - dpb_pkg::FRAC_BITS;
  localparam logic [P2W:0]  HALF    = (P2W+1)'(1) << (dpb_pkg::FRAC_BITS - 1);
  localparam logic [RW-1:0] POS_LIM = RW'(dpb_pkg::COORD_POS_MAX);
  localparam logic [RW-1:0] NEG_LIM = RW'(dpb_pkg::COORD_NEG_MAG);

  logic                            adv;
  logic [MAX_DIM_BITS-1:0]         qu, qv;
  logic [dpb_pkg::DEPTH_W-1:0]     qz;
  logic [DW-1:0]                   dx, dy;

  // Pipeline registers; the side fields travel along with the products.
  logic                            s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic                            s1_negx_r, s1_negy_r, s2_negx_r, s2_negy_r;
  logic                            s3_negx_r, s3_negy_r;
  logic [MW-1:0]                   s1_magx_r, s1_magy_r;
  logic [P1W-1:0]                  s2_px_r, s2_py_r;
  logic [P2W-1:0]                  s3_px_r, s3_py_r;
  logic [dpb_pkg::DEPTH_W-1:0]     s1_z_r, s2_z_r, s3_z_r;
  logic [dpb_pkg::POS_OUT_W-1:0]   s1_u_r, s2_u_r, s3_u_r, s1_v_r, s2_v_r, s3_v_r;
  logic [dpb_pkg::OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic [dpb_pkg::COORD_W-1:0]     pt_x, pt_y;

  // Round to nearest with ties away from zero, apply the sign and saturate.
  function automatic logic [dpb_pkg::COORD_W-1:0] round_sat(input logic [P2W-1:0] prod,
                                                           input logic neg);
    logic [P2W:0]  sum;
    logic [RW-1:0] mag;
    logic [RW-1:0] negmag;
    sum    = (P2W+1)'(prod) + HALF;
    mag    = sum[P2W:dpb_pkg::FRAC_BITS];
    negmag = -mag;
    if (neg) begin
      round_sat = (mag > NEG_LIM) ? dpb_pkg::COORD_W'(NEG_LIM)
                                  : negmag[dpb_pkg::COORD_W-1:0];
    end else begin
      round_sat = (mag > POS_LIM) ? dpb_pkg::COORD_W'(POS_LIM)
                                  : mag[dpb_pkg::COORD_W-1:0];
    end
  endfunction

  // The whole pipeline moves whenever the output register can take a value.
  assign adv        = !out_vld_r | out_tready;
  assign q_pop      = adv & !q_empty;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Offsets from the principal point in Q.4.
  assign {qv, qu, qz} = q_data;
  assign dx = (DW'(qu) << 4) - DW'(cfg.principal_x);
  assign dy = (DW'(qv) << 4) - DW'(cfg.principal_y);

  // Output stage values.
  assign pt_x = round_sat(s3_px_r, s3_negx_r);
  assign pt_y = round_sat(s3_py_r, s3_negy_r);
  assign out_data_nxt = {s3_v_r, s3_u_r, s3_z_r, pt_y, pt_x};

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= !q_empty;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
    end
  end

  // Datapath: offset magnitude, times depth, times reciprocal, round.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_negx_r  <= dx[DW-1];
      s1_negy_r  <= dy[DW-1];
      s1_magx_r  <= dx[DW-1] ? MW'(-dx) : MW'(dx);
      s1_magy_r  <= dy[DW-1] ? MW'(-dy) : MW'(dy);
      s1_z_r     <= qz;
      s1_u_r     <= dpb_pkg::POS_OUT_W'(qu);
      s1_v_r     <= dpb_pkg::POS_OUT_W'(qv);

      s2_negx_r  <= s1_negx_r;
      s2_negy_r  <= s1_negy_r;
      s2_px_r    <= P1W'(s1_magx_r) * P1W'(s1_z_r);
      s2_py_r    <= P1W'(s1_magy_r) * P1W'(s1_z_r);
      s2_z_r     <= s1_z_r;
      s2_u_r     <= s1_u_r;
      s2_v_r     <= s1_v_r;

      s3_negx_r  <= s2_negx_r;
      s3_negy_r  <= s2_negy_r;
      s3_px_r    <= P2W'(s2_px_r) * P2W'(cfg.inv_focal_x);
      s3_py_r    <= P2W'(s2_py_r) * P2W'(cfg.inv_focal_y);
      s3_z_r     <= s2_z_r;
      s3_u_r     <= s2_u_r;
      s3_v_r     <= s2_v_r;

      out_data_r <= out_data_nxt;
    end
  end

endmodule

FILE: rtl/depth_pixel_backprojection.sv
// Top level of the depth pixel backprojection block.
//
// Usage: depth pixels enter row-major on the in_ stream, one item per
// handshake; in_tuser marks the first pixel of a frame. The block counts
// column and row itself, keeps pixels whose column and row are multiples of
// the pixel step and whose depth does not exceed max_depth_mm, and emits one
// point (x, y, z, column, row) per kept pixel on the out_ stream.
// Throughput is one item per cycle: the front takes an item every cycle while
// the four-entry queue has room, and the back pipeline drains one per cycle
// while the receiver does not stall. An accepted item passes the queue, then
// the offset, depth multiply, reciprocal multiply and rounding stages. When the
// receiver stalls, the back pipeline holds, the queue fills, and in_tready drops
// once four kept pixels are waiting. Dropped pixels still need a free queue slot
// to be taken. Reset clears the position, the queue and the pipeline and loads
// the default registers; no clearing pass runs. The user must write registers
// through the cfg_ port only while the block is idle, which it does not enforce.
module depth_pixel_backprojection #(
  parameter int MAX_DIM_BITS = dpb_pkg::MAX_DIM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: depth_raw[15:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dpb_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: frame_start[0]
  input  logic [dpb_pkg::IN_USER_W-1:0]     in_tuser,
  // out_tdata: point_x[23:0], point_y[47:24], point_z[63:48],
  // pixel_col[75:64], pixel_row[87:76]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dpb_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [dpb_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int QW = dpb_pkg::DEPTH_W + 2 * MAX_DIM_BITS;

  dpb_pkg::cfg_t    cfg;
  logic             q_push, q_pop, q_full, q_empty;
  logic [QW-1:0]    q_in, q_head;

  dpb_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  dpb_front #(.MAX_DIM_BITS(MAX_DIM_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  dpb_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head_data (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  dpb_back #(.MAX_DIM_BITS(MAX_DIM_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_data     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/dpb_checker.sv
// Port-level checker of the depth backprojection block and its bind.
`include "depth_pixel_backprojection_macros.svh"

module dpb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dpb_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // A stalled result keeps its value until it is taken.
  `DPB_ASSERT_RUN(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // Reset empties the pipeline and the queue.
  `DPB_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid, "result valid right after reset")
  `DPB_ASSERT_ALWAYS(a_rst_in, !rst_n |=> in_tready, "input not ready right after reset")

  // A zero depth projects to the optical axis.
  `DPB_ASSERT_RUN(a_zero_depth, out_tvalid && out_tdata[63:48] == 16'd0 |-> out_tdata[47:0] == 48'd0, "zero depth gave a nonzero point")

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
